[design/ipid_pkg.sv]
// ----------------------------------------------------------------------------
// Incremental PID controller package
// Shared widths, defaults, register indexes and the stage tag type.
// ----------------------------------------------------------------------------
package ipid_pkg;

    localparam int GAIN_W      = 16;
    localparam int WINDOW_W    = 16;
    localparam int OUT_MAX_W   = 15;
    localparam int OUT_MIN_W   = 16;
    localparam int DRIVE_W     = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    localparam int DEF_ERROR_WIDTH  = 16;
    localparam int DEF_ACC_WIDTH    = 48;
    localparam int DEF_OUTPUT_SCALE = 1000;

    localparam logic [OUT_MAX_W-1:0]        OUT_MAX_RESET = '1;
    localparam logic signed [OUT_MIN_W-1:0] OUT_MIN_RESET = {1'b1, {(OUT_MIN_W-1){1'b0}}};

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_P     = 3'd0,
        CFG_GAIN_I     = 3'd1,
        CFG_GAIN_D     = 3'd2,
        CFG_INT_WINDOW = 3'd3,
        CFG_OUT_MAX    = 3'd4,
        CFG_OUT_MIN    = 3'd5
    } ipid_cfg_index_t;

    typedef struct packed {
        logic valid;
        logic integ;
    } ipid_tag_t;

endpackage

[design/ipid_drive.sv]
// ----------------------------------------------------------------------------
// Drive value scaling and clamp
// Three-stage pipeline: accumulator magnitude, reciprocal multiply for the
// division by the output scale, then symmetric clamp and result register.
// ----------------------------------------------------------------------------
module ipid_drive
    import ipid_pkg::*;
#(
    parameter int ACC_WIDTH    = DEF_ACC_WIDTH,
    parameter int OUTPUT_SCALE = DEF_OUTPUT_SCALE
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ipid_tag_t                    acc_tag,
    input  logic signed [ACC_WIDTH-1:0]  acc,
    output logic                         acc_ready,
    input  logic [OUT_MAX_W-1:0]         out_max,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DRIVE_W-1:0]    m_drive_value,
    output logic                         m_integral_applied
);

    localparam longint LIMIT    = longint'(OUTPUT_SCALE) * (longint'(1) << OUT_MAX_W);
    localparam int     X_W      = $clog2(LIMIT);
    localparam int     SC_LOG   = $clog2(OUTPUT_SCALE);
    localparam int     SHIFT    = X_W + SC_LOG;
    localparam int     RECIP_W  = X_W + 1;
    localparam int     PROD_W   = X_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << SHIFT) + longint'(OUTPUT_SCALE) - 1) / longint'(OUTPUT_SCALE));

    logic                  en3, en4, en5;
    ipid_tag_t             tag3_reg, tag4_reg;
    logic                  sign3_reg, big3_reg, sign4_reg, big4_reg;
    logic [X_W-1:0]        x3_reg;
    logic [PROD_W-1:0]     prod4_reg;
    logic [ACC_WIDTH-1:0]  acc_mag;
    logic [OUT_MAX_W-1:0]  quot;
    logic [OUT_MAX_W-1:0]  clamp_mag;
    logic [DRIVE_W-1:0]    mag_ext;
    logic [DRIVE_W-1:0]    drive_next;
    logic                  m_valid_reg;
    logic [DRIVE_W-1:0]    drive_reg;
    logic                  integ_reg;

    assign en5       = !m_valid_reg || m_ready;
    assign en4       = !tag4_reg.valid || en5;
    assign en3       = !tag3_reg.valid || en4;
    assign acc_ready = en3;

    assign acc_mag   = acc[ACC_WIDTH-1] ? (~acc + 1'b1) : acc;
    assign quot      = prod4_reg[SHIFT +: OUT_MAX_W];
    assign clamp_mag = (big4_reg || (quot > out_max)) ? out_max : quot;
    assign mag_ext   = DRIVE_W'(clamp_mag);
    assign drive_next = sign4_reg ? (~mag_ext + 1'b1) : mag_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag3_reg    <= '0;
            tag4_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (en3) begin
                tag3_reg <= acc_tag;
            end
            if (en4) begin
                tag4_reg <= tag3_reg;
            end
            if (en5) begin
                m_valid_reg <= tag4_reg.valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            sign3_reg      <= acc[ACC_WIDTH-1];
            big3_reg       <= acc_mag >= ACC_WIDTH'(LIMIT);
            x3_reg         <= acc_mag[X_W-1:0];
        end
        if (en4) begin
            sign4_reg      <= sign3_reg;
            big4_reg       <= big3_reg;
            prod4_reg      <= PROD_W'(x3_reg) * PROD_W'(RECIP);
        end
        if (en5) begin
            drive_reg <= drive_next;
            integ_reg <= tag4_reg.integ;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_drive_value      = drive_reg;
    assign m_integral_applied = integ_reg;

endmodule

[design/incremental_pid_controller.sv]
// ----------------------------------------------------------------------------
// Incremental PID controller with integral separation
// Accumulates proportional, integral and derivative increments of the error
// and presents the scaled, clamped drive value for each error request.
//
//   Channel   Ports                         Moves
//   s_        s_valid/s_ready               one error request
//   m_        m_valid/m_ready               drive value and integral flag
//   cfg_      cfg_write_en/index/data       one register write, no wait
//
// One request is accepted per cycle while s_ready is high.
// The accumulator update (three products summed and saturated) is the one
// feedback loop.
// Reset clears accumulator, history, gains, window; limits take defaults.
// A stall on m_ready fills the empty stages first, then holds s_ready low.
// ----------------------------------------------------------------------------
module incremental_pid_controller
    import ipid_pkg::*;
#(
    parameter int ERROR_WIDTH  = DEF_ERROR_WIDTH,
    parameter int ACC_WIDTH    = DEF_ACC_WIDTH,
    parameter int OUTPUT_SCALE = DEF_OUTPUT_SCALE
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_write_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [ERROR_WIDTH-1:0] s_error_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [DRIVE_W-1:0]     m_drive_value,
    output logic                          m_integral_applied
);

    localparam int D1_W   = ERROR_WIDTH + 1;
    localparam int D2_W   = ERROR_WIDTH + 2;
    localparam int PP_W   = GAIN_W + D1_W;
    localparam int PD_W   = GAIN_W + D2_W;
    localparam int PI_W   = GAIN_W + ERROR_WIDTH;
    localparam int INC_W  = GAIN_W + ERROR_WIDTH + 4;
    localparam int SUM_W  = ((ACC_WIDTH > INC_W) ? ACC_WIDTH : INC_W) + 1;
    localparam int CMP_W  = (ERROR_WIDTH > WINDOW_W) ? ERROR_WIDTH : WINDOW_W;
    localparam logic signed [ACC_WIDTH-1:0] ACC_TOP = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_BOT = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    logic signed [GAIN_W-1:0]      gain_p_reg, gain_i_reg, gain_d_reg;
    logic [WINDOW_W-1:0]           window_reg;
    logic [OUT_MAX_W-1:0]          out_max_reg;
    logic signed [OUT_MIN_W-1:0]   out_min_reg;

    logic signed [ERROR_WIDTH-1:0] e1_reg, e2_reg;
    logic                          accept, en2, drv_ready;

    logic signed [D1_W-1:0]        diff1;
    logic signed [D2_W-1:0]        diff2;
    logic [ERROR_WIDTH-1:0]        err_mag;
    logic                          in_window;

    logic                          v1_reg;
    logic signed [PP_W-1:0]        pp1_reg;
    logic signed [PD_W-1:0]        pd1_reg;
    logic signed [PI_W-1:0]        pi1_reg;
    logic                          win1_reg, neg1_reg, pos1_reg;

    logic                          integ;
    logic signed [SUM_W-1:0]       pi_sel, sum;
    logic signed [ACC_WIDTH-1:0]   acc_next, acc_reg;
    ipid_tag_t                     tag2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            window_reg  <= '0;
            out_max_reg <= OUT_MAX_RESET;
            out_min_reg <= OUT_MIN_RESET;
        end else if (cfg_write_en) begin
            unique case (cfg_index)
                CFG_GAIN_P:     gain_p_reg  <= cfg_data;
                CFG_GAIN_I:     gain_i_reg  <= cfg_data;
                CFG_GAIN_D:     gain_d_reg  <= cfg_data;
                CFG_INT_WINDOW: window_reg  <= cfg_data;
                CFG_OUT_MAX:    out_max_reg <= cfg_data[OUT_MAX_W-1:0];
                CFG_OUT_MIN:    out_min_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign en2     = !tag2_reg.valid || drv_ready;
    assign s_ready = !v1_reg || en2;
    assign accept  = s_valid && s_ready;

    assign diff1   = D1_W'(s_error_sample) - D1_W'(e1_reg);
    assign diff2   = D2_W'(s_error_sample) - (D2_W'(e1_reg) <<< 1) + D2_W'(e2_reg);
    assign err_mag = s_error_sample[ERROR_WIDTH-1] ? (~s_error_sample + 1'b1) : s_error_sample;
    assign in_window = CMP_W'(err_mag) <= CMP_W'(window_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_reg <= '0;
            e2_reg <= '0;
            v1_reg <= 1'b0;
        end else begin
            if (accept) begin
                e1_reg <= s_error_sample;
                e2_reg <= e1_reg;
            end
            if (s_ready) begin
                v1_reg <= s_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pp1_reg  <= PP_W'(gain_p_reg) * PP_W'(diff1);
            pd1_reg  <= PD_W'(gain_d_reg) * PD_W'(diff2);
            pi1_reg  <= PI_W'(gain_i_reg) * PI_W'(s_error_sample);
            win1_reg <= in_window;
            neg1_reg <= s_error_sample[ERROR_WIDTH-1];
            pos1_reg <= !s_error_sample[ERROR_WIDTH-1] && (s_error_sample != '0);
        end
    end

    always_comb begin
        if (!win1_reg) begin
            integ = 1'b0;
        end else if (acc_reg >= ACC_WIDTH'($signed({1'b0, out_max_reg}))) begin
            integ = neg1_reg;
        end else if (acc_reg <= ACC_WIDTH'(out_min_reg)) begin
            integ = pos1_reg;
        end else begin
            integ = 1'b1;
        end
    end

    assign pi_sel = integ ? SUM_W'(pi1_reg) : '0;
    assign sum    = SUM_W'(acc_reg) + SUM_W'(pp1_reg) + SUM_W'(pd1_reg) + pi_sel;

    always_comb begin
        if (sum > SUM_W'(ACC_TOP)) begin
            acc_next = ACC_TOP;
        end else if (sum < SUM_W'(ACC_BOT)) begin
            acc_next = ACC_BOT;
        end else begin
            acc_next = sum[ACC_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            tag2_reg <= '0;
        end else if (en2) begin
            tag2_reg.valid <= v1_reg;
            if (v1_reg) begin
                acc_reg        <= acc_next;
                tag2_reg.integ <= integ;
            end
        end
    end

    ipid_drive #(
        .ACC_WIDTH    (ACC_WIDTH),
        .OUTPUT_SCALE (OUTPUT_SCALE)
    ) u_drive (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .acc_tag            (tag2_reg),
        .acc                (acc_reg),
        .acc_ready          (drv_ready),
        .out_max            (out_max_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_drive_value      (m_drive_value),
        .m_integral_applied (m_integral_applied)
    );

endmodule

[design/ipid_checker.sv]
// ----------------------------------------------------------------------------
// Incremental PID controller port checker
// Watches the top-level ports for result stability, clamp range, the decoupling
// of the two channels and an empty result after reset.
// ----------------------------------------------------------------------------
module ipid_checker
    import ipid_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic signed [DRIVE_W-1:0] m_drive_value,
    input logic                      m_integral_applied
);

    localparam logic [DRIVE_W-1:0] MOST_NEG = {1'b1, {(DRIVE_W-1){1'b0}}};

    // An empty result register must never hold back a new request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while no result is pending");

    // The clamp is symmetric, so the most negative code never appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_drive_value != MOST_NEG))
        else $error("drive value outside the symmetric clamp");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_drive_value)
            && $stable(m_integral_applied))
        else $error("stalled result changed");

    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present right after reset");

endmodule

bind incremental_pid_controller ipid_checker u_ipid_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_drive_value      (m_drive_value),
    .m_integral_applied (m_integral_applied)
);
